@@ sv/fsmo_pkg.sv @@
// shared types and codes for the first substring match offset block
`timescale 1ns / 1ps

package fsmo_pkg;

   typedef enum logic {
      CMD_PATTERN = 1'b0,
      CMD_TEXT    = 1'b1
   } fsmo_cmd_type;

   typedef enum logic [1:0] {
      ST_MATCH    = 2'd0,
      ST_NO_MATCH = 2'd1,
      ST_TOO_LONG = 2'd2
   } fsmo_status_type;

   // broadcast controls from the top level to every cell
   typedef struct packed {
      logic clear;   // pattern beat: drop all partial matches
      logic shift;   // text beat: advance partial matches by one byte
      logic store;   // pattern beat that lands in a cell
   } fsmo_cell_ctl_type;

endpackage

@@ sv/fsmo_cell.sv @@
// one compare cell: a pattern byte and a partial match flag
`timescale 1ns / 1ps

module fsmo_cell
   import fsmo_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int LEN_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  fsmo_cell_ctl_type ctl,
   input  logic [7:0]        data_byte,
   input  logic [LEN_W-1:0]  wr_index,
   input  logic [LEN_W-1:0]  pat_len,
   input  logic              prev_match,
   output logic              match,
   output logic              hit
);

   logic [7:0] pat_ff;
   logic       match_ff;
   logic       match_in;
   logic       eq;

   assign eq = (data_byte == pat_ff);

   // pattern bytes 0..INDEX agree with the text ending at the newest byte
   always_comb begin
      priority if (ctl.clear) begin
         match_in = 1'b0;
      end else if (ctl.shift) begin
         match_in = prev_match && eq;
      end else begin
         match_in = match_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.store && wr_index == LEN_W'(INDEX)) begin
         pat_ff <= data_byte;
      end
   end

   assign match = match_ff;
   // full match when this cell holds the final pattern byte
   assign hit   = ctl.shift && prev_match && eq && (pat_len == LEN_W'(INDEX + 1));

endmodule

@@ sv/first_substring_match_offset.sv @@
// top level: pattern load, cell chain, text counter and result register
`timescale 1ns / 1ps

// Searches a byte stream for the first occurrence of a pattern. Pattern beats
// (tuser = 0) load up to PATTERN_MAX bytes, tlast closing the pattern; extra
// bytes are dropped. Text beats (tuser = 1) then stream through a row of
// PATTERN_MAX compare cells, each holding one pattern byte and a partial match
// flag that it hands to its neighbor on every text beat. The first full match,
// or the text beat with tlast, gives one result beat: status in tuser, start
// offset in tdata (the saturating text count minus the pattern length). Further
// text is dropped until the next pattern beat, which also restarts the search.
// One beat is taken every cycle, except while a result beat waits on rsp_tready;
// the result is registered and appears in the cycle after the deciding text beat.
// The cycle is set by one byte compare per cell and the OR over all cells, plus
// the offset subtract. No clearing pass after reset.
module first_substring_match_offset
   import fsmo_pkg::*;
#(
   parameter int PATTERN_MAX = 64,
   parameter int OFFSET_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic [0:0]  req_tuser,    // [0] cmd
   input  logic        req_tlast,    // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] match_offset
   output logic [1:0]  rsp_tuser     // [1:0] status
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   logic [LEN_W-1:0]       len_ff, len_in;
   logic                   load_open_ff, load_open_in;
   logic [OFFSET_BITS-1:0] count_ff, count_in, count_next;
   logic                   done_ff, done_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   fsmo_status_type        status_ff, status_in;
   logic [31:0]            offset_ff, offset_in;

   logic                   accept, is_pat, is_text, emit, any_hit;
   logic [LEN_W-1:0]       wr_index;
   logic [OFFSET_BITS-1:0] len_ext, offset_full;
   logic [63:0]            offset_wide;
   fsmo_cell_ctl_type      ctl;
   logic [PATTERN_MAX-1:0] match, hit;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_pat     = accept && (fsmo_cmd_type'(req_tuser[0]) == CMD_PATTERN);
   assign is_text    = accept && (fsmo_cmd_type'(req_tuser[0]) == CMD_TEXT) && !done_ff;

   // a pattern beat after a closed pattern starts over at index zero
   assign wr_index  = load_open_ff ? len_ff : '0;
   assign ctl.clear = is_pat;
   assign ctl.shift = is_text;
   assign ctl.store = is_pat && (wr_index < LEN_W'(PATTERN_MAX));

   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      fsmo_cell #(
         .INDEX (i),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .data_byte  (req_tdata),
         .wr_index   (wr_index),
         .pat_len    (len_ff),
         .prev_match ((i == 0) ? 1'b1 : match[(i == 0) ? 0 : i - 1]),
         .match      (match[i]),
         .hit        (hit[i])
      );
   end

   // an empty pattern matches on the first text byte
   assign any_hit     = (|hit) || (is_text && len_ff == '0);
   assign count_next  = (&count_ff) ? count_ff : count_ff + 1'b1;
   assign len_ext     = OFFSET_BITS'(len_ff);
   assign offset_full = count_next - len_ext;
   assign offset_wide = 64'(offset_full);
   assign emit        = is_text && (any_hit || req_tlast);

   always_comb begin
      len_in       = len_ff;
      load_open_in = load_open_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      if (is_pat) begin
         len_in       = ctl.store ? LEN_W'(wr_index + 1'b1) : wr_index;
         load_open_in = !req_tlast;
         count_in     = '0;
         done_in      = 1'b0;
      end else if (is_text) begin
         count_in = count_next;
         done_in  = emit;
      end
   end

   always_comb begin
      status_in = status_ff;
      offset_in = offset_ff;
      if (emit) begin
         priority if (any_hit) begin
            status_in = ST_MATCH;
            offset_in = offset_wide[31:0];
         end else if (count_next < len_ext) begin
            status_in = ST_TOO_LONG;
            offset_in = '0;
         end else begin
            status_in = ST_NO_MATCH;
            offset_in = '0;
         end
      end
   end

   always_comb begin
      priority if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         load_open_ff <= 1'b0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         load_open_ff <= load_open_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      offset_ff <= offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = offset_ff;
   assign rsp_tuser  = status_ff;

   a_emit_sets_done : assert property (@(posedge clock) disable iff (reset)
      emit |=> done_ff)
      else $error("search not closed after a result");

   a_pat_restarts : assert property (@(posedge clock) disable iff (reset)
      is_pat |=> (!done_ff && count_ff == '0))
      else $error("pattern beat did not restart the search");

   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(PATTERN_MAX))
      else $error("pattern length beyond capacity");

   a_offset_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_MATCH) |-> rsp_tdata == '0)
      else $error("offset set without a match");

   a_no_result_when_done : assert property (@(posedge clock) disable iff (reset)
      done_ff && !is_pat |=> !$rose(rsp_tvalid))
      else $error("result after the search closed");

endmodule
